@@ src/apt_pkg.sv @@
// Shared types and constants for the affine point transform.
// Fixed-point formats, matrix layout and configuration register map.
// No dependencies.
`default_nettype none
package apt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_REGS  = 8;
  localparam int CFG_W     = 2 * COORD_W;
  localparam int CFG_IDX_W = 8;
  localparam int REG_SEL_W = $clog2(NUM_REGS);
  localparam int NUM_COEF  = 16;

  localparam logic CMD_POINT     = 1'b0;
  localparam logic CMD_DIRECTION = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [CFG_W-1:0]   cfg_word_t;

  typedef coord_t [NUM_COEF-1:0] matrix_t;
  typedef prod_t  [NUM_COEF-1:0] prod_arr_t;
  typedef sum_t   [3:0]          sum_arr_t;
  typedef coord_t [3:0]          vec_t;

  localparam coord_t ONE_Q = coord_t'(64'sd1 <<< FRAC_BITS);

endpackage
`default_nettype wire

@@ src/affine_point_transform.sv @@
// Affine point transform top level: configuration registers and a
// three-stage multiply / sum / saturate pipeline. Depends on apt_pkg,
// apt_mul, apt_sum and apt_sat.
//
// Usage:
//   Input channel (in_valid / in_stall) carries command, in_x, in_y, in_z.
//   command 0 transforms a point (w = 1.0), 1 a direction (w = 0.0).
//   Output channel (out_valid / out_stall) carries out_x..out_w, saturated.
//   Each item is multiplied as a row vector by the 4x4 Q16.16 matrix held
//   in eight 64-bit registers written through write_enable / reg_index /
//   write_data; an index of eight or more is ignored.
//   An accepted item is registered after the multipliers, again after
//   the column adders and again after the clamp, then shows on out_valid.
//   Throughput is one item per cycle while out_stall is low; each stage
//   advances whenever it is empty or the stage after it moves.
//   Reset clears all stage valid bits and loads the identity matrix.
//   While the receiver stalls, the result holds and the pipeline keeps
//   filling; in_stall rises only when every stage holds an item.
`default_nettype none
module affine_point_transform (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          write_enable,
  input  wire logic [apt_pkg::CFG_IDX_W-1:0] reg_index,
  input  wire logic [apt_pkg::CFG_W-1:0]     write_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          command,
  input  wire apt_pkg::coord_t               in_x,
  input  wire apt_pkg::coord_t               in_y,
  input  wire apt_pkg::coord_t               in_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output apt_pkg::coord_t                    out_x,
  output apt_pkg::coord_t                    out_y,
  output apt_pkg::coord_t                    out_z,
  output apt_pkg::coord_t                    out_w,
  output logic                               saturated
);
  import apt_pkg::*;

  cfg_word_t  cfg [NUM_REGS];
  matrix_t    matrix;
  prod_arr_t  prod;
  sum_arr_t   sum;
  vec_t       result;
  logic       mul_valid, sum_valid;
  logic       mul_hold, sum_hold, sat_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[0] <= {{COORD_W{1'b0}}, ONE_Q};
      cfg[1] <= '0;
      cfg[2] <= {ONE_Q, {COORD_W{1'b0}}};
      cfg[3] <= '0;
      cfg[4] <= '0;
      cfg[5] <= {{COORD_W{1'b0}}, ONE_Q};
      cfg[6] <= '0;
      cfg[7] <= {ONE_Q, {COORD_W{1'b0}}};
    end else if (write_enable && (reg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg[reg_index[REG_SEL_W-1:0]] <= write_data;
    end
  end

  // even coefficient in the low half, odd in the high half
  always_comb begin
    for (int k = 0; k < NUM_COEF; k++) begin
      matrix[k] = cfg[k >> 1][(k % 2) * COORD_W +: COORD_W];
    end
  end

  apt_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (in_valid),
    .command   (command),
    .x         (in_x),
    .y         (in_y),
    .z         (in_z),
    .matrix    (matrix),
    .next_hold (sum_hold),
    .hold      (mul_hold),
    .valid     (mul_valid),
    .prod      (prod)
  );

  apt_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (mul_valid),
    .prod      (prod),
    .next_hold (sat_hold),
    .hold      (sum_hold),
    .valid     (sum_valid),
    .sum       (sum)
  );

  apt_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sum_valid),
    .sum       (sum),
    .next_hold (out_stall),
    .hold      (sat_hold),
    .valid     (out_valid),
    .result    (result),
    .sat_flag  (saturated)
  );

  assign in_stall = mul_hold;
  assign out_x    = result[0];
  assign out_y    = result[1];
  assign out_z    = result[2];
  assign out_w    = result[3];

`ifndef ASSERT_OFF
  localparam coord_t Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == Q_MAX) || (out_x == Q_MIN) || (out_y == Q_MAX) || (out_y == Q_MIN) ||
      (out_z == Q_MAX) || (out_z == Q_MIN) || (out_w == Q_MAX) || (out_w == Q_MIN))
    else $error("saturated flag without a clamped component");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !mul_valid && !sum_valid)
    else $error("pipeline not empty after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> mul_valid && sum_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");
`endif

endmodule
`default_nettype wire

@@ src/apt_mul.sv @@
// Multiply stage: all sixteen vector-by-coefficient products, registered.
// Depends on apt_pkg.
`default_nettype none
module apt_mul (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            valid_in,
  input  wire logic            command,
  input  wire apt_pkg::coord_t x,
  input  wire apt_pkg::coord_t y,
  input  wire apt_pkg::coord_t z,
  input  wire apt_pkg::matrix_t matrix,
  input  wire logic            next_hold,
  output logic                 hold,
  output logic                 valid,
  output apt_pkg::prod_arr_t   prod
);
  import apt_pkg::*;

  prod_arr_t prod_next;
  coord_t    vx [3];

  assign hold = valid && next_hold;

  always_comb begin
    vx[0] = x;
    vx[1] = y;
    vx[2] = z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_next[4*i+j] = prod_t'(vx[i]) * prod_t'(matrix[4*i+j]);
      end
    end
    // w is 1.0 or 0.0, so the last row is a shift or nothing
    for (int j = 0; j < 4; j++) begin
      prod_next[12+j] = (command == CMD_POINT) ?
                        (prod_t'(matrix[12+j]) <<< FRAC_BITS) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      prod <= prod_next;
    end
  end

endmodule
`default_nettype wire

@@ src/apt_sum.sv @@
// Sum stage: adds the four products of each column at full width.
// Depends on apt_pkg.
`default_nettype none
module apt_sum (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid_in,
  input  wire apt_pkg::prod_arr_t prod,
  input  wire logic               next_hold,
  output logic                    hold,
  output logic                    valid,
  output apt_pkg::sum_arr_t       sum
);
  import apt_pkg::*;

  sum_arr_t sum_next;

  assign hold = valid && next_hold;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum_next[j] = sum_t'(prod[j]) + sum_t'(prod[4+j]) +
                    sum_t'(prod[8+j]) + sum_t'(prod[12+j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      sum <= sum_next;
    end
  end

endmodule
`default_nettype wire

@@ src/apt_sat.sv @@
// Output stage: floor shift by the fraction width, clamp to 32 bits, flag.
// Holds the result register of the block. Depends on apt_pkg.
`default_nettype none
module apt_sat (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid_in,
  input  wire apt_pkg::sum_arr_t sum,
  input  wire logic              next_hold,
  output logic                   hold,
  output logic                   valid,
  output apt_pkg::vec_t          result,
  output logic                   sat_flag
);
  import apt_pkg::*;

  localparam int SH_W = SUM_W - FRAC_BITS;

  vec_t                    result_next;
  logic                    sat_next;
  logic signed [SH_W-1:0]  sh [4];
  logic [3:0]              clip;

  assign hold = valid && next_hold;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sh[j] = SH_W'(sum[j] >>> FRAC_BITS);
      // clamp when the bits above the sign of a 32-bit word disagree
      clip[j] = !((&sh[j][SH_W-1:COORD_W-1]) || !(|sh[j][SH_W-1:COORD_W-1]));
      if (clip[j]) begin
        result_next[j] = sh[j][SH_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                       : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        result_next[j] = sh[j][COORD_W-1:0];
      end
    end
    sat_next = |clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!hold) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      result   <= result_next;
      sat_flag <= sat_next;
    end
  end

endmodule
`default_nettype wire
